// ----- rtl/ncrc_pkg.sv -----
// Shared types and format codes for the numeric cast unit.
`timescale 1ns / 1ps
package ncrc_pkg;
	localparam logic [1:0] FMT_I32 = 2'd0;
	localparam logic [1:0] FMT_I64 = 2'd1;
	localparam logic [1:0] FMT_F32 = 2'd2;
	localparam logic [1:0] FMT_F64 = 2'd3;

	localparam logic REG_SOURCE_TYPE = 1'b0;
	localparam logic REG_TARGET_TYPE = 1'b1;

	typedef struct packed {
		logic [63:0] value_bits;
		logic        value_present;
	} cast_in_t;

	typedef struct packed {
		logic [63:0] result_bits;
		logic        result_present;
		logic        cast_status;
	} cast_out_t;

	// Unpacked operand: sign, magnitude as integer mantissa times 2^exp.
	// For integers exp is 0; for normal floats the mantissa carries the hidden bit.
	typedef struct packed {
		logic              present;
		logic              passthru;
		logic              bad;
		logic [1:0]        tgt;
		logic [63:0]       raw;
		logic              sign;
		logic [63:0]       mag;
		logic signed [12:0] expo;
	} cast_unp_t;

	// Normalised operand: msb index of mag known.
	typedef struct packed {
		logic              present;
		logic              passthru;
		logic              bad;
		logic [1:0]        tgt;
		logic [63:0]       raw;
		logic              sign;
		logic [63:0]       mag;
		logic signed [12:0] expo;
		logic              zero;
		logic [5:0]        msb;
	} cast_norm_t;
endpackage

// ----- rtl/ncrc_unpack.sv -----
// Stage 1: split the source value into sign, magnitude and exponent.
`timescale 1ns / 1ps
module ncrc_unpack import ncrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  cast_in_t   item,
	input  logic [1:0] source_type,
	input  logic [1:0] target_type,
	output logic       valid_s1,
	output cast_unp_t  unp_s1
);
	cast_unp_t u;
	logic [31:0] lo;

	always_comb begin
		lo = item.value_bits[31:0];
		u = '0;
		u.present  = item.value_present;
		u.tgt      = target_type;
		u.passthru = source_type == target_type;
		u.raw      = (source_type == FMT_I32 || source_type == FMT_F32) ?
			{32'd0, lo} : item.value_bits;
		case (source_type)
			FMT_I32: begin
				u.sign = lo[31];
				u.mag  = lo[31] ? {32'd0, (~lo) + 32'd1} : {32'd0, lo};
				u.expo = '0;
			end
			FMT_I64: begin
				u.sign = item.value_bits[63];
				u.mag  = item.value_bits[63] ? (~item.value_bits) + 64'd1
					: item.value_bits;
				u.expo = '0;
			end
			FMT_F32: begin
				u.sign = lo[31];
				u.bad  = lo[30:23] == 8'hFF;
				if (lo[30:23] == 8'd0) begin
					u.mag  = {41'd0, lo[22:0]};
					u.expo = -13'sd149;
				end else begin
					u.mag  = {40'd0, 1'b1, lo[22:0]};
					u.expo = $signed({5'd0, lo[30:23]}) - 13'sd150;
				end
			end
			default: begin
				u.sign = item.value_bits[63];
				u.bad  = item.value_bits[62:52] == 11'h7FF;
				if (item.value_bits[62:52] == 11'd0) begin
					u.mag  = {12'd0, item.value_bits[51:0]};
					u.expo = -13'sd1074;
				end else begin
					u.mag  = {11'd0, 1'b1, item.value_bits[51:0]};
					u.expo = $signed({2'd0, item.value_bits[62:52]}) - 13'sd1075;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		unp_s1 <= u;
	end
endmodule

// ----- rtl/ncrc_lzd.sv -----
// Stage 2: find the leading one of the magnitude.
`timescale 1ns / 1ps
module ncrc_lzd import ncrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  cast_unp_t  unp_s1,
	output logic       valid_s2,
	output cast_norm_t norm_s2
);
	cast_norm_t n;

	always_comb begin
		n.present  = unp_s1.present;
		n.passthru = unp_s1.passthru;
		n.bad      = unp_s1.bad;
		n.tgt      = unp_s1.tgt;
		n.raw      = unp_s1.raw;
		n.sign     = unp_s1.sign;
		n.mag      = unp_s1.mag;
		n.expo     = unp_s1.expo;
		n.zero     = unp_s1.mag == 64'd0;
		n.msb      = '0;
		// priority encoder over independent bits
		for (int i = 0; i < 64; i++) begin
			if (unp_s1.mag[i]) n.msb = 6'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		norm_s2 <= n;
	end
endmodule

// ----- rtl/ncrc_convert.sv -----
// Stages 3 and 4: shift to the target, round or truncate, range check, pack.
`timescale 1ns / 1ps
module ncrc_convert import ncrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  cast_norm_t norm_s2,
	output logic       valid_s4,
	output cast_out_t  res_s4
);
	// Stage 3 working set
	typedef struct packed {
		logic        present;
		logic        passthru;
		logic        bad;
		logic        ovf;
		logic [1:0]  tgt;
		logic [63:0] raw;
		logic        sign;
		logic        zero;
		logic [63:0] ival;      // truncated integer magnitude
		logic [53:0] frac;      // mantissa incl. hidden bit, pre-rounding
		logic        rnd;
		logic        stk;
		logic signed [12:0] fexp; // biased target exponent
		logic [5:0]  fw;        // fraction width 23 or 52
	} cast_mid_t;

	cast_mid_t m, mid_s3;
	logic signed [13:0] e;       // unbiased exponent of the leading one
	logic signed [13:0] sh;
	logic [127:0] wide, shl;
	logic [5:0] p;
	logic signed [13:0] emin, bias;
	logic [6:0] rsh;
	logic fr;                    // bits dropped by truncation
	logic valid_s3;

	always_comb begin
		m = '0;
		m.present  = norm_s2.present;
		m.passthru = norm_s2.passthru;
		m.bad      = norm_s2.bad;
		m.tgt      = norm_s2.tgt;
		m.raw      = norm_s2.raw;
		m.sign     = norm_s2.sign;
		m.zero     = norm_s2.zero;
		e = 14'(norm_s2.expo) + 14'($signed({1'b0, norm_s2.msb}));
		wide = {64'd0, norm_s2.mag};
		shl = '0;
		sh = '0;
		rsh = '0;
		fr = 1'b0;
		p = (norm_s2.tgt == FMT_F32) ? 6'd23 : 6'd52;
		m.fw = p;
		emin = (norm_s2.tgt == FMT_F32) ? -14'sd126 : -14'sd1022;
		bias = (norm_s2.tgt == FMT_F32) ? 14'sd127 : 14'sd1023;
		if (norm_s2.tgt == FMT_I32 || norm_s2.tgt == FMT_I64) begin
			// truncate toward zero: value = mag * 2^expo
			if (norm_s2.expo >= 0) begin
				m.ival = norm_s2.mag << norm_s2.expo[5:0];
				m.ovf  = !norm_s2.zero && (e > 14'sd63);
			end else if (norm_s2.expo > -13'sd64) begin
				rsh = 7'($unsigned(-norm_s2.expo));
				m.ival = norm_s2.mag >> rsh;
				fr = (norm_s2.mag & ((64'd1 << rsh) - 64'd1)) != 64'd0;
			end else begin
				m.ival = '0;
				fr = !norm_s2.zero;
			end
			if (norm_s2.tgt == FMT_I32) begin
				m.ovf = m.ovf || (norm_s2.sign ?
					(e > 14'sd31) || (m.ival > 64'h80000000)
					|| (m.ival == 64'h80000000 && fr)
					: (m.ival > 64'h7FFFFFFF) || (m.ival == 64'h7FFFFFFF && fr));
			end else begin
				m.ovf = m.ovf || (norm_s2.sign ? (m.ival > 64'h8000000000000000)
					: m.ival[63]);
			end
		end else begin
			// float target: place leading one at bit p, with two extra bits
			if (e < emin) sh = 14'($signed({1'b0, p})) - 14'($signed({1'b0, norm_s2.msb}))
				- (emin - e);
			else sh = 14'($signed({1'b0, p})) - 14'($signed({1'b0, norm_s2.msb}));
			if (sh >= 0) begin
				shl = wide << sh[6:0];
				m.frac = shl[53:0];
			end else begin
				shl = (sh < -14'sd127) ? 128'd0 : (wide << 64) >> 7'($unsigned(-sh));
				m.frac = 54'(shl[127:64]);
				m.rnd = shl[63];
				m.stk = shl[62:0] != 63'd0;
			end
			m.fexp = (e < emin) ? 13'sd0 : 13'(e + bias);
			// range check on float32 target: flags any value above the largest finite value, before rounding
			m.ovf = !norm_s2.zero && (norm_s2.tgt == FMT_F32) && (e > 14'sd127 ||
				(e == 14'sd127 && sh < 0 && shl[87:64] == 24'hFFFFFF
				&& (shl[63:0] != 64'd0)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mid_s3 <= m;
	end

	// Stage 4: round float results to nearest even and pack
	cast_out_t r;
	logic [54:0] rf;
	logic signed [13:0] fe;
	logic [63:0] fbits, ibits;

	always_comb begin
		rf = {1'b0, mid_s3.frac} + 55'(mid_s3.rnd && (mid_s3.stk || mid_s3.frac[0]));
		fe = 14'(mid_s3.fexp);
		if (mid_s3.fw == 6'd23) begin
			if (rf[24]) begin
				fe = fe + 14'sd1;
				rf = rf >> 1;
			end else if (fe == 0 && rf[23]) begin
				fe = 14'sd1;
			end
			fbits = {32'd0, mid_s3.sign, fe[7:0], rf[22:0]};
		end else begin
			if (rf[53]) begin
				fe = fe + 14'sd1;
				rf = rf >> 1;
			end else if (fe == 0 && rf[52]) begin
				fe = 14'sd1;
			end
			fbits = {mid_s3.sign, fe[10:0], rf[51:0]};
		end
		// keep the sign of a zero
		if (mid_s3.zero) fbits = (mid_s3.fw == 6'd23) ? {32'd0, mid_s3.sign, 31'd0}
			: {mid_s3.sign, 63'd0};
		ibits = mid_s3.sign ? (~mid_s3.ival) + 64'd1 : mid_s3.ival;
		if (mid_s3.tgt == FMT_I32) ibits = {32'd0, ibits[31:0]};
		r.result_present = mid_s3.present;
		r.cast_status = 1'b0;
		r.result_bits = '0;
		if (!mid_s3.present) begin
			r.result_bits = '0;
		end else if (mid_s3.passthru) begin
			r.result_bits = mid_s3.raw;
		end else if (mid_s3.bad || mid_s3.ovf) begin
			r.cast_status = 1'b1;
		end else if (mid_s3.tgt == FMT_I32 || mid_s3.tgt == FMT_I64) begin
			r.result_bits = ibits;
		end else begin
			r.result_bits = fbits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= r;
	end
endmodule

// ----- rtl/numeric_cast_range_check_unit.sv -----
// Top level of the numeric cast and range check unit.
`timescale 1ns / 1ps
//  channel  | handshake          | payload
//  command  | start, busy        | item (cast_in_t)
//  result   | done (strobe)      | result (cast_out_t)
//  config   | cfg_we, cfg_index  | cfg_data
// One item per cycle; each item passes through the four register stages:
// unpack, leading-one search, shift and range check, round and pack.
// busy is never raised.
// Reset clears the valid bits and both format registers to int32.
// The receiver cannot stall; done lasts one cycle per item.
module numeric_cast_range_check_unit import ncrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cast_in_t   item,
	output logic       done,
	output cast_out_t  result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);
	logic [1:0] source_type_q, target_type_q;
	logic       valid_s1, valid_s2;
	cast_unp_t  unp_s1;
	cast_norm_t norm_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_type_q <= FMT_I32;
			target_type_q <= FMT_I32;
		end else if (cfg_we) begin
			if (cfg_index == REG_SOURCE_TYPE) source_type_q <= cfg_data;
			else target_type_q <= cfg_data;
		end
	end

	ncrc_unpack u_unpack (
		.clk, .arst_n, .start, .item,
		.source_type(source_type_q), .target_type(target_type_q),
		.valid_s1, .unp_s1
	);

	ncrc_lzd u_lzd (.clk, .arst_n, .valid_s1, .unp_s1, .valid_s2, .norm_s2);

	ncrc_convert u_convert (
		.clk, .arst_n, .valid_s2, .norm_s2,
		.valid_s4(done), .res_s4(result)
	);

	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.result_present |-> result.result_bits == 64'd0
			&& !result.cast_status) else $error("absent item not zero");
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.cast_status |-> result.result_bits == 64'd0)
		else $error("flagged item not zero");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done) else $error("item lost in pipeline");
endmodule
